FILE: design/acs_pkg.sv
// Package for the accumulator machine step block: codes, item types and helpers.
// Used by the channel interfaces, the top level, the memory and the checker.
package acs_pkg;

  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Bytes per bank; offsets wrap with a mask, so this stays a power of two.
  localparam int BANK_BYTES = 4096;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILE_DEV  = 1'd1;
  localparam logic [15:0] MAX_STEPS_RESET = 16'd1000;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_EXEC  = 2'd2;

  localparam logic [3:0] OP_JMP   = 4'd0;
  localparam logic [3:0] OP_JZ    = 4'd1;
  localparam logic [3:0] OP_JN    = 4'd2;
  localparam logic [3:0] OP_CTRL  = 4'd3;
  localparam logic [3:0] OP_ADD   = 4'd4;
  localparam logic [3:0] OP_SUB   = 4'd5;
  localparam logic [3:0] OP_MUL   = 4'd6;
  localparam logic [3:0] OP_DIV   = 4'd7;
  localparam logic [3:0] OP_LOAD  = 4'd8;
  localparam logic [3:0] OP_STORE = 4'd9;
  localparam logic [3:0] OP_CALL  = 4'd10;
  localparam logic [3:0] OP_OS    = 4'd11;
  localparam logic [3:0] OP_IO    = 4'd12;

  localparam logic [3:0] SUB_HALT     = 4'd0;
  localparam logic [3:0] SUB_INDIRECT = 4'd2;

  localparam logic [2:0] STS_OK      = 3'd0;
  localparam logic [2:0] STS_HALTED  = 3'd1;
  localparam logic [2:0] STS_BAD_OP  = 3'd2;
  localparam logic [2:0] STS_DIV0    = 3'd3;
  localparam logic [2:0] STS_NO_DEV  = 3'd4;
  localparam logic [2:0] STS_LIMIT   = 3'd5;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_LOWA  = 8'd97;
  localparam logic [7:0] ASCII_LOWA_BIAS = 8'd87;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_BYTE0, ST_BYTE1, ST_DECODE, ST_PTR_HI, ST_PTR_LO,
    ST_OPER, ST_DIVIDE, ST_CALL_LO, ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  mem_bank;
    logic [11:0] mem_offset;
    logic [7:0]  mem_data;
    logic [7:0]  in_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              out_valid;
    logic [2:0]        out_devices;
    logic [7:0]        out_byte;
    logic signed [7:0] acc_value;
    logic [11:0]       pc_offset;
    logic [3:0]        pc_bank;
  } res_item_t;

  // Control, OS and I/O instructions are one byte long.
  function automatic logic op_is_short(input logic [3:0] code);
    return (code == OP_CTRL) || (code == OP_OS) || (code == OP_IO);
  endfunction

  // Device 1 turns an ASCII digit or lowercase hex digit into its value; bytes below '0' and high bytes pass unchanged.
  function automatic logic [7:0] hex_in(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (!b[7]) begin
      if (b >= ASCII_ZERO && b < ASCII_LOWA) r = b - ASCII_ZERO;
      else if (b >= ASCII_LOWA) r = b - ASCII_LOWA_BIAS;
    end
    return r;
  endfunction

endpackage

FILE: design/acs_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on acs_pkg for the payload types.
interface acs_in_if;
  import acs_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface acs_out_if;
  import acs_pkg::*;
  logic      valid;
  logic      ready;
  res_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/acs_mem.sv
// Single-port byte memory with a registered read, read-before-write.
// Depends on acs_pkg for the byte width.
module acs_mem #(
  parameter int DEPTH = 65536,
  parameter int AW = 16
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             addr,
  input  logic [acs_pkg::BYTE_W-1:0] wdata,
  output logic [acs_pkg::BYTE_W-1:0] rdata
);
  import acs_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

FILE: design/acs_div.sv
// Signed 8-bit divider, restoring, one quotient bit per cycle, truncating.
// Stand-alone; used by the top level for the divide instruction.
module acs_div (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] dividend,
  input  logic [7:0] divisor,
  output logic       done,
  output logic [7:0] quot
);
  logic       busy;
  logic [2:0] cnt;
  logic [7:0] num;
  logic [7:0] den;
  logic [8:0] rem;
  logic       neg;
  logic [8:0] shifted;
  logic [8:0] diff;
  logic       ge;

  assign shifted = {rem[7:0], num[7]};
  assign diff    = shifted - {1'b0, den};
  assign ge      = !diff[8];
  assign quot    = neg ? 8'(-num) : num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // Magnitudes; the magnitude of -128 is 0x80 read as unsigned.
      num <= dividend[7] ? 8'(-dividend) : dividend;
      den <= divisor[7] ? 8'(-divisor) : divisor;
      rem <= '0;
      neg <= dividend[7] ^ divisor[7];
    end else if (busy) begin
      rem <= ge ? diff : shifted;
      num <= {num[6:0], ge};
    end
  end
endmodule

FILE: design/accumulator_cpu_step.sv
// Top level of the accumulator machine step block.
// Depends on acs_pkg, acs_if, acs_mem and acs_div.
//
// Usage: input items arrive on in_ch (valid/ready) and each one yields exactly
// one result item on out_ch. An item writes a memory byte, starts the machine
// at an offset, or executes one instruction. Configuration (step limit, file
// device presence) is written through cfg_we/cfg_index/cfg_data while idle.
//
// All machine memory sits in one single-port synchronous RAM with a registered
// read. An instruction is a short sequence of reads and writes on that port:
// opcode byte, optional operand byte, optional two pointer bytes, then an
// operand read or a store (a call writes two bytes). A divide also waits for
// the bit-serial divider. One item is worked on at a time; the next input
// transfer is taken once the previous result has moved into the output
// register.
//
// Reset is synchronous. After reset the block sweeps the whole memory to zero,
// one byte per cycle (NUM_BANKS * BANK_BYTES bytes, 65536 by default), and
// keeps in_ch.ready low during that sweep. If the receiver stalls, the result
// holds in the output register and a finished next item waits for its slot.
module accumulator_cpu_step #(
  parameter int NUM_BANKS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [acs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [acs_pkg::CFG_DATA_W-1:0]   cfg_data,
  acs_in_if.sink                           in_ch,
  acs_out_if.source                        out_ch
);
  import acs_pkg::*;

  localparam int OFF_W  = $clog2(BANK_BYTES);
  localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int DEPTH  = NUM_BANKS * BANK_BYTES;
  localparam int AW     = BANK_W + OFF_W;

  // Bank number taken modulo NUM_BANKS; each candidate range is checked apart.
  function automatic logic [BANK_W-1:0] bank_mod(input logic [3:0] v);
    logic [BANK_W-1:0] r;
    r = '0;
    for (int k = 0; k < 16; k++) begin
      if (int'(v) >= k * NUM_BANKS && int'(v) < (k + 1) * NUM_BANKS)
        r = BANK_W'(int'(v) - k * NUM_BANKS);
    end
    return r;
  endfunction

  // Sequencer and architectural state.
  seq_state_t        state, state_next;
  logic [7:0]        acc, acc_next;
  logic [OFF_W-1:0]  pc, pc_next;
  logic [BANK_W-1:0] bank, bank_next;
  logic              ind, ind_next;
  logic              running, running_next;
  logic [15:0]       steps, steps_next;
  logic [15:0]       max_steps;
  logic              file_dev;
  logic [AW-1:0]     clr_addr;

  // Per-item working registers.
  logic [7:0]  b0, b0_next;
  logic [11:0] opnd, opnd_next;
  logic [7:0]  p_hi, p_hi_next;
  logic [7:0]  in_byte, in_byte_next;
  logic [2:0]  res_st, res_st_next;
  logic        res_put, res_put_next;
  logic [2:0]  res_dev, res_dev_next;
  logic [7:0]  res_byte, res_byte_next;

  // Output register.
  logic      out_full;
  res_item_t out_item;
  logic      out_free;

  // Memory port.
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;

  // Divider.
  logic       div_start;
  logic       div_done;
  logic [7:0] div_q;

  // Decode of the current instruction.
  logic             in_fire;
  logic [3:0]       code;
  logic [3:0]       sub;
  logic             is_short;
  logic             is_jump;
  logic             is_alu;
  logic             take;
  logic [OFF_W-1:0] opnd_off;
  logic [OFF_W-1:0] ret_off;
  logic [15:0]      ret_word;
  logic [BANK_W-1:0] ptr_bank;
  logic [OFF_W-1:0] ptr_off;
  logic [1:0]       dev;
  logic [2:0]       present;
  logic [2:0]       dev_mask;
  logic             finish;
  logic             redirect;
  logic [OFF_W-1:0] target;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == ST_IDLE);
  assign out_free = !out_full || out_ch.ready;
  assign out_ch.valid = out_full;
  assign out_ch.data  = out_item;

  assign code     = b0[7:4];
  assign sub      = b0[3:0];
  assign is_short = op_is_short(code);
  assign is_jump  = (code == OP_JMP) || (code == OP_JZ) || (code == OP_JN);
  assign is_alu   = (code >= OP_ADD) && (code <= OP_STORE);
  assign take     = (code == OP_JMP) || ((code == OP_JZ) && (acc == 8'd0)) ||
                    ((code == OP_JN) && acc[7]);
  assign opnd_off = opnd[OFF_W-1:0];
  assign ret_off  = pc + OFF_W'(2);
  assign ret_word = 16'(ret_off);
  assign ptr_bank = bank_mod(p_hi[7:4]);
  assign ptr_off  = OFF_W'({p_hi[3:0], mem_rdata});
  assign dev      = sub[1:0];
  assign present  = {1'b0, file_dev, 1'b1};
  assign dev_mask = (dev == 2'd0) ? present : 3'(3'b001 << (dev - 2'd1));

  acs_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  acs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (mem_rdata),
    .done     (div_done),
    .quot     (div_q)
  );

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.data.action == ACT_EXEC && running && steps < max_steps)
            state_next = ST_BYTE0;
          else
            state_next = ST_EMIT;
        end
      end
      ST_BYTE0: begin
        if (mem_rdata[7:4] > OP_IO) state_next = ST_EMIT;
        else if (!op_is_short(mem_rdata[7:4]) || ind) state_next = ST_BYTE1;
        else state_next = ST_DECODE;
      end
      ST_BYTE1: state_next = ST_DECODE;
      ST_DECODE: begin
        if ((is_jump && take && ind) || (is_alu && ind)) state_next = ST_PTR_HI;
        else if (is_alu && code != OP_STORE) state_next = ST_OPER;
        else if (code == OP_CALL) state_next = ST_CALL_LO;
        else state_next = ST_EMIT;
      end
      ST_PTR_HI: state_next = ST_PTR_LO;
      ST_PTR_LO: begin
        if (is_jump || code == OP_STORE) state_next = ST_EMIT;
        else state_next = ST_OPER;
      end
      ST_OPER: begin
        if (code == OP_DIV && mem_rdata != 8'd0) state_next = ST_DIVIDE;
        else state_next = ST_EMIT;
      end
      ST_DIVIDE: begin
        if (div_done) state_next = ST_EMIT;
      end
      ST_CALL_LO: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory accesses and next values of the machine state.
  always_comb begin
    acc_next      = acc;
    pc_next       = pc;
    bank_next     = bank;
    ind_next      = ind;
    running_next  = running;
    steps_next    = steps;
    b0_next       = b0;
    opnd_next     = opnd;
    p_hi_next     = p_hi;
    in_byte_next  = in_byte;
    res_st_next   = res_st;
    res_put_next  = res_put;
    res_dev_next  = res_dev;
    res_byte_next = res_byte;
    mem_we        = 1'b0;
    mem_addr      = {bank, pc};
    mem_wdata     = acc;
    div_start     = 1'b0;
    finish        = 1'b0;
    redirect      = 1'b0;
    target        = opnd_off;

    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = 8'd0;
      end
      ST_IDLE: begin
        if (in_fire) begin
          res_st_next   = STS_OK;
          res_put_next  = 1'b0;
          res_dev_next  = 3'd0;
          res_byte_next = 8'd0;
          in_byte_next  = in_ch.data.in_byte;
          case (in_ch.data.action)
            ACT_WRITE: begin
              mem_we    = 1'b1;
              mem_addr  = {bank_mod(in_ch.data.mem_bank), in_ch.data.mem_offset[OFF_W-1:0]};
              mem_wdata = in_ch.data.mem_data;
            end
            ACT_START: begin
              pc_next      = in_ch.data.mem_offset[OFF_W-1:0];
              running_next = 1'b1;
            end
            ACT_EXEC: begin
              // The opcode read at bank:pc is issued here in any case.
              if (!running) res_st_next = STS_HALTED;
              else if (steps >= max_steps) res_st_next = STS_LIMIT;
            end
            default: ;
          endcase
        end
      end
      ST_BYTE0: begin
        b0_next   = mem_rdata;
        opnd_next = {mem_rdata[3:0], 8'h00};
        mem_addr  = {bank, pc + OFF_W'(1)};
        if (mem_rdata[7:4] > OP_IO) begin
          running_next = 1'b0;
          res_st_next  = STS_BAD_OP;
        end
      end
      ST_BYTE1: begin
        opnd_next = {b0[3:0], mem_rdata};
      end
      ST_DECODE: begin
        if (is_short) ind_next = 1'b0;
        mem_addr = {bank, opnd_off};
        if (is_jump) begin
          if (!take) begin
            finish = 1'b1;
          end else if (!ind) begin
            finish   = 1'b1;
            redirect = 1'b1;
            target   = opnd_off;
          end
        end else if (is_alu) begin
          // Either the pointer's high byte or the operand is read; a direct
          // store writes now.
          if (!ind && code == OP_STORE) begin
            mem_we = 1'b1;
            finish = 1'b1;
          end
        end else if (code == OP_CALL) begin
          mem_we    = 1'b1;
          mem_wdata = ret_word[15:8];
        end else if (code == OP_CTRL) begin
          finish = 1'b1;
          if (sub == SUB_HALT) begin
            running_next = 1'b0;
            res_st_next  = STS_HALTED;
          end else if (sub == SUB_INDIRECT) begin
            ind_next = 1'b1;
          end
        end else if (code == OP_OS) begin
          finish = 1'b1;
        end else begin
          finish = 1'b1;
          if (sub[2]) begin
            if (dev != 2'd0 && (present & dev_mask) == 3'd0) begin
              res_st_next = STS_NO_DEV;
            end else begin
              res_put_next  = 1'b1;
              res_dev_next  = dev_mask;
              res_byte_next = acc;
            end
          end else if (!sub[3] && dev != 2'd0) begin
            if ((present & dev_mask) == 3'd0) begin
              // A get from an absent device stops the machine and does not count.
              finish       = 1'b0;
              running_next = 1'b0;
              res_st_next  = STS_NO_DEV;
            end else begin
              acc_next = (dev == 2'd1) ? hex_in(in_byte) : in_byte;
            end
          end
        end
      end
      ST_PTR_HI: begin
        p_hi_next = mem_rdata;
        mem_addr  = {bank, opnd_off + OFF_W'(1)};
      end
      ST_PTR_LO: begin
        ind_next = 1'b0;
        mem_addr = {ptr_bank, ptr_off};
        if (is_jump) begin
          bank_next = ptr_bank;
          finish    = 1'b1;
          redirect  = 1'b1;
          target    = ptr_off;
        end else if (code == OP_STORE) begin
          mem_we = 1'b1;
          finish = 1'b1;
        end
      end
      ST_OPER: begin
        case (code)
          OP_ADD: begin
            acc_next = acc + mem_rdata;
            finish   = 1'b1;
          end
          OP_SUB: begin
            acc_next = acc - mem_rdata;
            finish   = 1'b1;
          end
          OP_MUL: begin
            acc_next = 8'(acc * mem_rdata);
            finish   = 1'b1;
          end
          OP_DIV: begin
            if (mem_rdata == 8'd0) begin
              res_st_next = STS_DIV0;
              finish      = 1'b1;
            end else begin
              div_start = 1'b1;
            end
          end
          default: begin
            acc_next = mem_rdata;
            finish   = 1'b1;
          end
        endcase
      end
      ST_DIVIDE: begin
        if (div_done) begin
          acc_next = div_q;
          finish   = 1'b1;
        end
      end
      ST_CALL_LO: begin
        mem_we    = 1'b1;
        mem_addr  = {bank, opnd_off + OFF_W'(1)};
        mem_wdata = ret_word[7:0];
        finish    = 1'b1;
        redirect  = 1'b1;
        target    = opnd_off + OFF_W'(2);
      end
      ST_EMIT: ;
      default: ;
    endcase

    if (finish) begin
      pc_next    = redirect ? target : (pc + (is_short ? OFF_W'(1) : OFF_W'(2)));
      steps_next = steps + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      acc       <= 8'd0;
      pc        <= OFF_W'(1);
      bank      <= '0;
      ind       <= 1'b0;
      running   <= 1'b0;
      steps     <= 16'd0;
      max_steps <= MAX_STEPS_RESET;
      file_dev  <= 1'b0;
      clr_addr  <= '0;
      out_full  <= 1'b0;
    end else begin
      state   <= state_next;
      acc     <= acc_next;
      pc      <= pc_next;
      bank    <= bank_next;
      ind     <= ind_next;
      running <= running_next;
      steps   <= steps_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_STEPS: max_steps <= cfg_data;
          CFG_FILE_DEV:  file_dev  <= cfg_data[0];
          default: ;
        endcase
      end
      if (state == ST_EMIT && out_free) out_full <= 1'b1;
      else if (out_ch.ready) out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    b0       <= b0_next;
    opnd     <= opnd_next;
    p_hi     <= p_hi_next;
    in_byte  <= in_byte_next;
    res_st   <= res_st_next;
    res_put  <= res_put_next;
    res_dev  <= res_dev_next;
    res_byte <= res_byte_next;
    if (state == ST_EMIT && out_free) begin
      out_item.status      <= res_st;
      out_item.out_valid   <= res_put;
      out_item.out_devices <= res_dev;
      out_item.out_byte    <= res_byte;
      out_item.acc_value   <= signed'(acc);
      out_item.pc_offset   <= 12'(pc);
      out_item.pc_bank     <= 4'(bank);
    end
  end
endmodule

FILE: design/acs_checker.sv
// Port-level checker for the accumulator machine step block, with its bind.
// Depends on acs_pkg; attaches to accumulator_cpu_step.
module acs_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic       res_put,
  input logic [2:0] res_dev,
  input logic [7:0] res_byte
);
  import acs_pkg::*;

  // Results still owed: input transfers minus output transfers.
  logic [1:0] owed;

  always_ff @(posedge clk) begin
    if (rst) begin
      owed <= 2'd0;
    end else begin
      owed <= owed + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> owed != 2'd0)
    else $error("result without a matching input transfer");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    owed != 2'd3)
    else $error("too many items outstanding");

  a_clear_busy: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input taken during memory clear");

  a_quiet_put: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res_put |-> res_dev == 3'd0 && res_byte == 8'd0 && status <= STS_LIMIT)
    else $error("put fields set without a put");
endmodule

bind accumulator_cpu_step acs_checker u_acs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .status    (out_ch.data.status),
  .res_put   (out_ch.data.out_valid),
  .res_dev   (out_ch.data.out_devices),
  .res_byte  (out_ch.data.out_byte)
);
